// ===== hw/rtl/spd_pkg.sv =====
`default_nettype none
package spd_pkg;

  localparam int unsigned COUNT_W = 17;
  localparam int unsigned LEN_W = COUNT_W + 1;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // Packet layout: six header bytes, CRC high byte at length field + 5
  localparam logic [COUNT_W-1:0] HDR_BYTES = COUNT_W'(6);
  localparam logic [COUNT_W-1:0] CRC_OFS = COUNT_W'(5);
  localparam logic [LEN_W-1:0] MIN_BUF_BYTES = LEN_W'(8);
  localparam logic [LEN_W-1:0] FRAME_OVERHEAD = LEN_W'(7);

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_SHORT = 3'd1;
  localparam logic [2:0] ST_BAD_VERSION = 3'd2;
  localparam logic [2:0] ST_ZERO_LENGTH = 3'd3;
  localparam logic [2:0] ST_TRUNCATED = 3'd4;
  localparam logic [2:0] ST_CRC_MISMATCH = 3'd5;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       end_of_buffer;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [10:0] apid;
    logic        packet_type;
    logic        secondary_header;
    logic [13:0] sequence_count;
    logic [15:0] payload_length;
  } out_item_t;

  // CRC-16-CCITT, MSB first, one byte
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/spd_in_stage.sv =====
`default_nettype none
module spd_in_stage (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire spd_pkg::in_item_t in_data,
  input  wire logic              take,
  output logic                   item_valid,
  output spd_pkg::in_item_t      item
);
  import spd_pkg::*;

  logic     valid;
  in_item_t data;

  assign in_ready = !valid || take;
  assign item_valid = valid;
  assign item = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      valid <= 1'b1;
    end else if (take) begin
      valid <= 1'b0;
    end
  end

  // hold the byte until the core takes it
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data <= in_data;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/spd_core.sv =====
`default_nettype none
module spd_core (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_valid,
  input  wire logic [2:0]        cfg_data,
  input  wire logic              item_valid,
  input  wire spd_pkg::in_item_t item,
  input  wire logic              out_free,
  output logic                   take,
  output logic                   push,
  output spd_pkg::out_item_t     result
);
  import spd_pkg::*;

  logic [2:0]         version;
  logic [15:0]        hw [3];
  logic [COUNT_W-1:0] byte_count;
  logic [15:0]        crc;
  logic [15:0]        rcrc;

  logic [15:0]        hw_next [3];
  logic [COUNT_W-1:0] count_next;
  logic [15:0]        crc_next;
  logic [15:0]        rcrc_next;
  logic [COUNT_W-1:0] crc_pos;
  logic [LEN_W-1:0]   in_len;
  logic [LEN_W-1:0]   need_len;
  logic [2:0]         status;
  logic               last;

  assign last = item.end_of_buffer;
  // a non-final byte never produces a verdict, so it never waits on the output
  assign take = item_valid && (!last || out_free);
  assign push = take && last;

  always_comb begin
    hw_next = hw;
    crc_next = crc;
    rcrc_next = rcrc;
    crc_pos = {1'b0, hw[2]} + CRC_OFS;
    if (byte_count < HDR_BYTES) begin
      for (int i = 0; i < 3; i++) begin
        if (byte_count[2:1] == 2'(i)) begin
          if (byte_count[0]) begin
            hw_next[i][7:0] = item.rx_byte;
          end else begin
            hw_next[i][15:8] = item.rx_byte;
          end
        end
      end
      crc_next = crc_byte(crc, item.rx_byte);
    end else if (byte_count < crc_pos) begin
      crc_next = crc_byte(crc, item.rx_byte);
    end else if (byte_count == crc_pos) begin
      rcrc_next[15:8] = item.rx_byte;
    end else if (byte_count == crc_pos + COUNT_W'(1)) begin
      rcrc_next[7:0] = item.rx_byte;
    end
    count_next = (byte_count != COUNT_MAX) ? byte_count + COUNT_W'(1) : byte_count;
  end

  always_comb begin
    in_len = {1'b0, byte_count} + LEN_W'(1);
    need_len = {2'b00, hw_next[2]} + FRAME_OVERHEAD;
    if (in_len < MIN_BUF_BYTES) begin
      status = ST_SHORT;
    end else if (hw_next[0][15:13] != version) begin
      status = ST_BAD_VERSION;
    end else if (hw_next[2] == 16'd0) begin
      status = ST_ZERO_LENGTH;
    end else if (need_len > in_len) begin
      status = ST_TRUNCATED;
    end else if (rcrc_next != crc_next) begin
      status = ST_CRC_MISMATCH;
    end else begin
      status = ST_OK;
    end

    result.status = status;
    if (status == ST_SHORT) begin
      result.apid = '0;
      result.packet_type = 1'b0;
      result.secondary_header = 1'b0;
      result.sequence_count = '0;
      result.payload_length = '0;
    end else begin
      result.apid = hw_next[0][10:0];
      result.packet_type = hw_next[0][12];
      result.secondary_header = hw_next[0][11];
      result.sequence_count = hw_next[1][13:0];
      result.payload_length = (hw_next[2] == 16'd0) ? 16'd0 : hw_next[2] - 16'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      version <= 3'd0;
    end else if (cfg_valid) begin
      version <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        hw[i] <= 16'd0;
      end
      byte_count <= '0;
      crc <= CRC_INIT;
      rcrc <= 16'd0;
    end else if (take) begin
      if (last) begin
        // drop all packet state for the next buffer
        for (int i = 0; i < 3; i++) begin
          hw[i] <= 16'd0;
        end
        byte_count <= '0;
        crc <= CRC_INIT;
        rcrc <= 16'd0;
      end else begin
        hw <= hw_next;
        byte_count <= count_next;
        crc <= crc_next;
        rcrc <= rcrc_next;
      end
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/spd_out_stage.sv =====
`default_nettype none
module spd_out_stage (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  input  wire spd_pkg::out_item_t result,
  output logic                    out_free,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output spd_pkg::out_item_t      out_data
);
  import spd_pkg::*;

  logic      valid;
  out_item_t data;

  assign out_free = !valid || out_ready;
  assign out_valid = valid;
  assign out_data = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (push) begin
      valid <= 1'b1;
    end else if (out_ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      data <= result;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/space_packet_decoder.sv =====
// Space packet decoder: checks the primary header and CRC-16-CCITT trailer
// of a received buffer, one byte per transfer.
// Input channel in_valid/in_ready/in_data carries one byte and an
// end-of-buffer flag. Output channel out_valid/out_ready/out_data carries one
// verdict (status and decoded header fields) per buffer, produced only for
// the byte that carries the end-of-buffer flag.
// Config channel cfg_valid/cfg_ready/cfg_data sets the expected packet
// version; it is always ready and should be written only while idle.
// Verdicts are formed combinationally from the input register and registered
// once the output register is free. Throughput: one byte per cycle unless a
// final byte waits on a stalled output, set by the unrolled CRC byte update.
// Reset clears the header capture, byte counter and version (to zero) and sets the CRC to 0xFFFF.
// When the receiver stalls with a verdict pending, non-final bytes still
// flow; a further final byte waits in the input register until the pending
// verdict is taken, and in_ready drops behind it.
`default_nettype none
module space_packet_decoder (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire spd_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output spd_pkg::out_item_t      out_data,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [2:0]         cfg_data
);
  import spd_pkg::*;

  logic      take;
  logic      push;
  logic      out_free;
  logic      item_valid;
  in_item_t  item;
  out_item_t result;

  assign cfg_ready = 1'b1;

  spd_in_stage u_in (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .take      (take),
    .item_valid(item_valid),
    .item      (item)
  );

  spd_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .item_valid(item_valid),
    .item      (item),
    .out_free  (out_free),
    .take      (take),
    .push      (push),
    .result    (result)
  );

  spd_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .result   (result),
    .out_free (out_free),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

endmodule
`default_nettype wire

// ===== hw/rtl/spd_checker.sv =====
`default_nettype none
module spd_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire spd_pkg::out_item_t out_data
);
  import spd_pkg::*;

  // stalled verdict holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output transfer dropped or changed while stalled");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.status <= ST_CRC_MISMATCH)
    else $error("status code out of range");

  a_short_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status == ST_SHORT |->
      out_data.apid == 11'd0 && out_data.sequence_count == 14'd0 &&
      out_data.payload_length == 16'd0 && !out_data.packet_type &&
      !out_data.secondary_header)
    else $error("short buffer verdict carries header fields");

  a_zero_len: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status == ST_ZERO_LENGTH |-> out_data.payload_length == 16'd0)
    else $error("zero length verdict with nonzero payload length");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("block not idle after reset");

endmodule

bind space_packet_decoder spd_checker u_spd_checker (
  .clk      (clk),
  .rst      (rst),
  .in_ready (in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data (out_data)
);
`default_nettype wire
